### sv/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the texture slot batcher
// Field widths, slot table sizing, token and result structs, controller states.
// ----------------------------------------------------------------------------
package tsb_pkg;

  // slot table sizing
  localparam int SLOTS        = 32;
  localparam int QUAD_INDICES = 6;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USED_W       = $clog2(SLOTS + 1);

  // field widths
  localparam int TEX_W  = 32;
  localparam int PX_W   = 5;
  localparam int PY_W   = 7;
  localparam int PZ_W   = 5;
  localparam int FACE_W = 3;
  localparam int TSL_W  = 7;
  localparam int VIDX_W = 5;
  localparam int DRAW_W = 16;
  localparam int IDX_W  = 24;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [USED_W-1:0] used_t;
  typedef logic [TSL_W-1:0]  tex_slot_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DRAW_W-1:0] draw_t;

  localparam used_t SLOTS_USED = used_t'(SLOTS);
  localparam draw_t DRAW_MAX   = '1;
  localparam idx_t  INDEX_MAX  = '1;
  localparam idx_t  QUAD_IDX   = idx_t'(QUAD_INDICES);
  localparam idx_t  IDX_LIMIT  = idx_t'((1 << IDX_W) - 1 - QUAD_INDICES);

  // request modes
  localparam logic MODE_QUAD    = 1'b0;
  localparam logic MODE_REBUILD = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [TEX_W-1:0]  texture_id;
    logic [PX_W-1:0]   pos_x;
    logic [PY_W-1:0]   pos_y;
    logic [PZ_W-1:0]   pos_z;
    logic [FACE_W-1:0] face;
  } tsb_quad_t;

  typedef struct packed {
    logic              vertex_valid;
    logic [31:0]       vertex_word;
    logic [TSL_W-1:0]  texture_slot;
    logic              new_texture;
    logic [TEX_W-1:0]  bound_texture;
    logic              new_draw_call;
    logic [DRAW_W-1:0] draw_call;
    logic [IDX_W-1:0]  draw_index_count;
    logic              last;
  } tsb_vertex_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [TEX_W-1:0] tex;
  } tsb_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } tsb_state_e;

endpackage

### sv/tsb_quad_if.sv
// ----------------------------------------------------------------------------
// tsb_quad_if: quad request channel
// Valid/ready channel carrying one quad or rebuild request per transfer.
// ----------------------------------------------------------------------------
interface tsb_quad_if;
  logic              valid;
  logic              ready;
  tsb_pkg::tsb_quad_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/tsb_vertex_if.sv
// ----------------------------------------------------------------------------
// tsb_vertex_if: packed vertex result channel
// Valid/ready channel carrying one vertex word or rebuild acknowledgement.
// ----------------------------------------------------------------------------
interface tsb_vertex_if;
  logic                valid;
  logic                ready;
  tsb_pkg::tsb_vertex_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/tsb_slot_cell.sv
// ----------------------------------------------------------------------------
// tsb_slot_cell: one bound texture slot
// Holds one slot entry, compares the passing search token against it and
// hands the token on to the next cell when it does not match.
// ----------------------------------------------------------------------------
module tsb_slot_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsb_pkg::tsb_tok_t           tok_i,
  input  logic                        flush_i,
  input  logic                        wr_en_i,
  input  logic [tsb_pkg::TEX_W-1:0]   wr_data_i,
  output tsb_pkg::tsb_tok_t           tok_o,
  output logic                        hit_o
);

  logic [tsb_pkg::TEX_W-1:0] entry_q;
  tsb_pkg::tsb_tok_t         tok_q, tok_d;

  // slot entry, written when this slot is bound
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  // token stage
  always_comb begin
    tok_d = tok_i;
    if (flush_i) begin
      tok_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // local compare; a matched token stops here
  assign hit_o       = tok_q.valid && (tok_q.tex == entry_q);
  assign tok_o.valid = tok_q.valid && !hit_o;
  assign tok_o.tex   = tok_q.tex;

endmodule

### sv/texture_slot_batcher_vertex_packer_core.sv
// ----------------------------------------------------------------------------
// texture_slot_batcher_vertex_packer_core: texture slot binding and vertex packing
// Searches the bound slots for a quad's texture through a chain of slot
// cells, binds it on a miss (opening a new draw call when full), then packs
// four vertex words.
// ----------------------------------------------------------------------------
//
//  channel    dir  payload        transfer carries
//  quad_i     in   tsb_quad_t     one quad or rebuild request
//  vertex_o   out  tsb_vertex_t   one vertex word or rebuild acknowledgement
//
// A quad is accepted, then its token walks the slot cells in search, up to
// the hit slot or over all bound slots (no search with an empty table), then
// the update state binds on a miss and the emit state sends four vertex words.
// A rebuild skips to emit. The output register lets a request be taken
// while the last result still waits; a stalled output holds the emit state.
// Reset is asynchronous and needs no clearing pass; unbound slots are never read.
// ----------------------------------------------------------------------------
module texture_slot_batcher_vertex_packer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsb_quad_if.sink      quad_i,
  tsb_vertex_if.source  vertex_o
);

  tsb_pkg::tsb_state_e state_q, state_d;

  // latched request
  tsb_pkg::tsb_quad_t  req_q;

  // search and binding state
  tsb_pkg::slot_t      pos_q, pos_d;
  tsb_pkg::slot_t      slot_q, slot_d;
  logic                found_q, found_d;
  logic                fresh_tex_q, fresh_tex_d;
  logic                fresh_draw_q, fresh_draw_d;
  logic                rebuild_q, rebuild_d;
  logic [1:0]          corner_q, corner_d;
  tsb_pkg::used_t      used_q, used_d;
  tsb_pkg::draw_t      draw_q, draw_d;
  tsb_pkg::idx_t       idx_q, idx_d;

  // output register
  logic                out_valid_q;
  tsb_pkg::tsb_vertex_t out_q;

  // control
  logic                accept;
  logic                inject;
  logic                flush;
  logic                out_free;
  logic                out_load;
  logic                hit_any;
  logic                last_pos;
  logic                table_full;
  tsb_pkg::slot_t      bind_slot;
  tsb_pkg::idx_t       idx_base;
  tsb_pkg::tsb_vertex_t res;

  // cell chain
  tsb_pkg::tsb_tok_t   tok_chain [tsb_pkg::SLOTS+1];
  logic [tsb_pkg::SLOTS-1:0] hit_vec;
  logic [tsb_pkg::SLOTS-1:0] wr_vec;

  assign tok_chain[0].valid = inject;
  assign tok_chain[0].tex   = quad_i.payload.texture_id;

  for (genvar g = 0; g < tsb_pkg::SLOTS; g++) begin : g_cell
    tsb_slot_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok_chain[g]),
      .flush_i   (flush),
      .wr_en_i   (wr_vec[g]),
      .wr_data_i (req_q.texture_id),
      .tok_o     (tok_chain[g+1]),
      .hit_o     (hit_vec[g])
    );
  end

  // only the cell holding the token can hit
  assign hit_any  = |hit_vec;
  assign last_pos = (tsb_pkg::used_t'(pos_q) == (used_q - tsb_pkg::used_t'(1)));
  assign out_free = !out_valid_q || vertex_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsb_pkg::ST_IDLE: begin
        if (accept) begin
          if (quad_i.payload.mode == tsb_pkg::MODE_REBUILD) begin
            state_d = tsb_pkg::ST_EMIT;
          end else if (used_q == '0) begin
            state_d = tsb_pkg::ST_UPDATE;
          end else begin
            state_d = tsb_pkg::ST_SEARCH;
          end
        end
      end
      tsb_pkg::ST_SEARCH: begin
        if (hit_any || last_pos) begin
          state_d = tsb_pkg::ST_UPDATE;
        end
      end
      tsb_pkg::ST_UPDATE: begin
        state_d = tsb_pkg::ST_EMIT;
      end
      tsb_pkg::ST_EMIT: begin
        if (out_free && (rebuild_q || (corner_q == 2'd3))) begin
          state_d = tsb_pkg::ST_IDLE;
        end
      end
      default: state_d = tsb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    quad_i.ready = 1'b0;
    flush        = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      tsb_pkg::ST_IDLE:   quad_i.ready = 1'b1;
      tsb_pkg::ST_SEARCH: flush        = hit_any || last_pos;
      tsb_pkg::ST_UPDATE: ;
      tsb_pkg::ST_EMIT:   out_load     = out_free;
      default: ;
    endcase
  end

  assign accept = quad_i.valid && quad_i.ready;
  assign inject = accept && (quad_i.payload.mode == tsb_pkg::MODE_QUAD) && (used_q != '0);

  // binding on a miss
  assign table_full = (used_q == tsb_pkg::SLOTS_USED);
  assign bind_slot  = table_full ? '0 : tsb_pkg::slot_t'(used_q);
  assign idx_base   = (!found_q && table_full) ? '0 : idx_q;

  always_comb begin
    for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
      wr_vec[i] = (state_q == tsb_pkg::ST_UPDATE) && !found_q &&
                  (bind_slot == tsb_pkg::slot_t'(i));
    end
  end

  // datapath next values
  always_comb begin
    pos_d        = pos_q;
    slot_d       = slot_q;
    found_d      = found_q;
    fresh_tex_d  = fresh_tex_q;
    fresh_draw_d = fresh_draw_q;
    rebuild_d    = rebuild_q;
    corner_d     = corner_q;
    used_d       = used_q;
    draw_d       = draw_q;
    idx_d        = idx_q;
    case (state_q)
      tsb_pkg::ST_IDLE: begin
        if (accept) begin
          pos_d        = '0;
          found_d      = 1'b0;
          fresh_tex_d  = 1'b0;
          fresh_draw_d = 1'b0;
          corner_d     = '0;
          rebuild_d    = (quad_i.payload.mode == tsb_pkg::MODE_REBUILD);
          if (quad_i.payload.mode == tsb_pkg::MODE_REBUILD) begin
            used_d = '0;
            draw_d = '0;
            idx_d  = '0;
          end
        end
      end
      tsb_pkg::ST_SEARCH: begin
        if (hit_any) begin
          found_d = 1'b1;
          slot_d  = pos_q;
        end else if (!last_pos) begin
          pos_d = pos_q + tsb_pkg::slot_t'(1);
        end
      end
      tsb_pkg::ST_UPDATE: begin
        if (!found_q) begin
          slot_d      = bind_slot;
          fresh_tex_d = 1'b1;
          used_d      = (table_full ? '0 : used_q) + tsb_pkg::used_t'(1);
          if (table_full) begin
            fresh_draw_d = 1'b1;
            if (draw_q != tsb_pkg::DRAW_MAX) begin
              draw_d = draw_q + tsb_pkg::draw_t'(1);
            end
          end
        end
        // saturating index count
        if (idx_base > tsb_pkg::IDX_LIMIT) begin
          idx_d = tsb_pkg::INDEX_MAX;
        end else begin
          idx_d = idx_base + tsb_pkg::QUAD_IDX;
        end
      end
      tsb_pkg::ST_EMIT: begin
        if (out_free) begin
          corner_d = corner_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsb_pkg::ST_IDLE;
      pos_q        <= '0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      fresh_tex_q  <= 1'b0;
      fresh_draw_q <= 1'b0;
      rebuild_q    <= 1'b0;
      corner_q     <= '0;
      used_q       <= '0;
      draw_q       <= '0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      slot_q       <= slot_d;
      found_q      <= found_d;
      fresh_tex_q  <= fresh_tex_d;
      fresh_draw_q <= fresh_draw_d;
      rebuild_q    <= rebuild_d;
      corner_q     <= corner_d;
      used_q       <= used_d;
      draw_q       <= draw_d;
      idx_q        <= idx_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= quad_i.payload;
    end
  end

  // result for the current corner
  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (!rebuild_q) begin
      res.vertex_valid     = 1'b1;
      res.vertex_word      = {3'b000, tsb_pkg::tex_slot_t'(slot_q), req_q.face, corner_q,
                              req_q.pos_z, req_q.pos_y, req_q.pos_x};
      res.texture_slot     = tsb_pkg::tex_slot_t'(slot_q);
      res.new_texture      = (corner_q == 2'd0) && fresh_tex_q;
      res.bound_texture    = res.new_texture ? req_q.texture_id : '0;
      res.new_draw_call    = (corner_q == 2'd0) && fresh_draw_q;
      res.draw_call        = draw_q;
      res.draw_index_count = idx_q;
      res.last             = (corner_q == 2'd3);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (vertex_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign vertex_o.valid   = out_valid_q;
  assign vertex_o.payload = out_q;

  // checks
  logic [tsb_pkg::SLOTS-1:0] tok_vec;
  always_comb begin
    for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
      tok_vec[i] = tok_chain[i+1].valid || hit_vec[i];
    end
  end

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the slot chain");

  a_hit_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_any |-> (state_q == tsb_pkg::ST_SEARCH))
    else $error("slot hit outside search");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= tsb_pkg::SLOTS_USED)
    else $error("bound slot count beyond table size");

  a_rebuild_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (quad_i.payload.mode == tsb_pkg::MODE_REBUILD))
      |=> (used_q == '0) && (draw_q == '0) && (idx_q == '0))
    else $error("rebuild did not clear batch state");

endmodule
